// ----- design/waveform_generator_with_range_alarm_macros.svh -----
// ----------------------------------------------------------------------------
// Waveform generator assertion macros
// Shared property shapes for the checker of the waveform generator.
// ----------------------------------------------------------------------------
`ifndef WAVEFORM_GENERATOR_WITH_RANGE_ALARM_MACROS_SVH
`define WAVEFORM_GENERATOR_WITH_RANGE_ALARM_MACROS_SVH

// same-cycle implication, held off during reset
`define WGRA_ASSERT_NOW(name, clk, rst_n, pre, post, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error(msg);

// next-cycle implication, held off during reset
`define WGRA_ASSERT_NEXT(name, clk, rst_n, pre, post, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

// ----- design/wgra_pkg.sv -----
// ----------------------------------------------------------------------------
// wgra_pkg
// Types, constants and the sine table builder of the waveform generator.
// ----------------------------------------------------------------------------
`default_nettype none

package wgra_pkg;

    localparam int SINE_TABLE_DEPTH   = 1024;
    localparam int SINE_FRACTION_BITS = 16;
    localparam int SINE_INDEX_W       = $clog2(SINE_TABLE_DEPTH);
    localparam int SINE_ENTRY_W       = SINE_FRACTION_BITS + 2;
    localparam int SINE_SHIFT         = 30 - SINE_FRACTION_BITS;

    localparam int PHASE_W    = 32;
    localparam int COUNT_W    = 32;
    localparam int AMP_W      = 23;
    localparam int LEVEL_W    = 27;
    localparam int SAMPLE_W   = 28;
    localparam int MAG_W      = 33;
    localparam int PROD_W     = AMP_W + MAG_W;
    localparam int WAVE_MAG_W = AMP_W + 1;
    localparam int WAVE_W     = WAVE_MAG_W + 1;
    localparam int SUM_W      = SAMPLE_W + 1;

    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

    localparam logic [1:0] WAVE_SINE   = 2'd0;
    localparam logic [1:0] WAVE_SQUARE = 2'd1;
    localparam logic [1:0] WAVE_SAW    = 2'd2;
    localparam logic [1:0] WAVE_NOISE  = 2'd3;

    localparam logic [2:0] CFG_WAVE_SHAPE   = 3'd0;
    localparam logic [2:0] CFG_AMPLITUDE    = 3'd1;
    localparam logic [2:0] CFG_PHASE_STEP   = 3'd2;
    localparam logic [2:0] CFG_LEVEL_OFFSET = 3'd3;
    localparam logic [2:0] CFG_UPPER_LIMIT  = 3'd4;
    localparam logic [2:0] CFG_LOWER_LIMIT  = 3'd5;

    localparam logic [PHASE_W-1:0] PHASE_HALF = 32'h8000_0000;
    localparam logic [COUNT_W-1:0] COUNT_MAX  = 32'hFFFF_FFFF;
    localparam logic [31:0]        LFSR_TAPS  = 32'hD000_0001;
    localparam logic [31:0]        LFSR_SEED  = 32'h0000_0001;

    localparam logic signed [SAMPLE_W-1:0] SAMPLE_LIMIT = 28'sd72089600;

    localparam logic [63:0] Q30_ONE     = 64'd1073741824;
    localparam logic [63:0] Q30_TWO_PI  = 64'd6746518852;
    localparam logic [63:0] Q30_PI      = 64'd3373259426;
    localparam logic [63:0] Q30_HALF_PI = 64'd1686629713;

    typedef struct packed {
        logic [1:0]                wave_shape;
        logic [AMP_W-1:0]          amplitude;
        logic [PHASE_W-1:0]        phase_step;
        logic signed [LEVEL_W-1:0] level_offset;
        logic signed [LEVEL_W-1:0] upper_limit;
        logic signed [LEVEL_W-1:0] lower_limit;
    } t_cfg;

    typedef struct packed {
        logic [1:0]         shape;
        logic [PHASE_W-1:0] phase;
        logic               first;
        logic [COUNT_W-1:0] count;
    } t_job;

    typedef logic signed [SINE_ENTRY_W-1:0] t_sine_rom [SINE_TABLE_DEPTH];

    function automatic logic signed [SINE_ENTRY_W-1:0] sine_entry(input logic [63:0] idx);
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] t;
        logic [63:0] s;
        logic [63:0] r;
        logic        neg;
        logic signed [SINE_ENTRY_W-1:0] mag;
        x   = (idx * Q30_TWO_PI) / SINE_TABLE_DEPTH;
        neg = 1'b0;
        if (x >= Q30_PI) begin
            x   = x - Q30_PI;
            neg = 1'b1;
        end
        if (x > Q30_HALF_PI) begin
            x = Q30_PI - x;
        end
        x2  = (x * x) >> 30;
        t   = Q30_ONE;
        t   = Q30_ONE - ((x2 * t) >> 30) / 64'd272;
        t   = Q30_ONE - ((x2 * t) >> 30) / 64'd210;
        t   = Q30_ONE - ((x2 * t) >> 30) / 64'd156;
        t   = Q30_ONE - ((x2 * t) >> 30) / 64'd110;
        t   = Q30_ONE - ((x2 * t) >> 30) / 64'd72;
        t   = Q30_ONE - ((x2 * t) >> 30) / 64'd42;
        t   = Q30_ONE - ((x2 * t) >> 30) / 64'd20;
        t   = Q30_ONE - ((x2 * t) >> 30) / 64'd6;
        s   = (x * t) >> 30;
        r   = (s + (64'd1 << (SINE_SHIFT - 1))) >> SINE_SHIFT;
        mag = r[SINE_ENTRY_W-1:0];
        return neg ? -mag : mag;
    endfunction

    function automatic t_sine_rom sine_rom_init();
        t_sine_rom rom;
        for (int i = 0; i < SINE_TABLE_DEPTH; i++) begin
            rom[i] = sine_entry(64'(i));
        end
        return rom;
    endfunction

endpackage

`default_nettype wire

// ----- design/wgra_front.sv -----
// ----------------------------------------------------------------------------
// wgra_front
// Accepts sample requests, tracks sample count and noise LFSR, forms the phase.
// ----------------------------------------------------------------------------
`default_nettype none

module wgra_front (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire wgra_pkg::t_cfg  i_cfg,
    input  wire                  i_valid,
    output logic                 o_ready,
    input  wire                  i_restart,
    output logic                 o_push,
    output wgra_pkg::t_job       o_job,
    input  wire                  i_full
);
    import wgra_pkg::*;

    logic                 r_busy;
    logic [COUNT_W-1:0]   r_count;
    logic [COUNT_W-1:0]   r_cur;
    logic [31:0]          r_lfsr;
    logic                 w_accept;
    logic [COUNT_W-1:0]   n_base;
    logic [COUNT_W-1:0]   n_count;
    logic [31:0]          n_lfsr;
    logic [PHASE_W-1:0]   w_phase_prod;

    assign o_ready  = ~r_busy;
    assign w_accept = i_valid & ~r_busy;

    always_comb begin
        n_base  = i_restart ? '0 : r_count;
        n_count = (n_base == COUNT_MAX) ? n_base : n_base + COUNT_W'(1);
        n_lfsr  = {1'b0, r_lfsr[31:1]} ^ (r_lfsr[0] ? LFSR_TAPS : '0);
    end

    assign w_phase_prod = i_cfg.phase_step * r_cur;

    assign o_push      = r_busy & ~i_full;
    assign o_job.shape = i_cfg.wave_shape;
    assign o_job.phase = (i_cfg.wave_shape == WAVE_NOISE) ? r_lfsr : w_phase_prod;
    assign o_job.first = (r_cur == '0);
    assign o_job.count = r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_count <= '0;
            r_lfsr  <= LFSR_SEED;
        end else if (w_accept) begin
            r_busy  <= 1'b1;
            r_count <= n_count;
            if (i_cfg.wave_shape == WAVE_NOISE) begin
                r_lfsr <= n_lfsr;
            end
        end else if (o_push) begin
            r_busy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_cur <= n_base;
        end
    end

endmodule

`default_nettype wire

// ----- design/wgra_queue.sv -----
// ----------------------------------------------------------------------------
// wgra_queue
// Short job queue between the front and the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module wgra_queue (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_push,
    input  wire wgra_pkg::t_job  i_job,
    output logic                 o_full,
    input  wire                  i_pop,
    output wgra_pkg::t_job       o_job,
    output logic                 o_empty
);
    import wgra_pkg::*;

    t_job                   r_mem [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] r_wr_ptr;
    logic [QUEUE_PTR_W-1:0] r_rd_ptr;
    logic [QUEUE_CNT_W-1:0] r_fill;
    logic                   w_wr;
    logic                   w_rd;

    assign o_full  = (r_fill == QUEUE_CNT_W'(QUEUE_DEPTH));
    assign o_empty = (r_fill == '0);
    assign w_wr    = i_push & ~o_full;
    assign w_rd    = i_pop & ~o_empty;
    assign o_job   = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_fill   <= '0;
        end else begin
            if (w_wr) begin
                r_wr_ptr <= (r_wr_ptr == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (w_rd) begin
                r_rd_ptr <= (r_rd_ptr == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (w_wr && !w_rd) begin
                r_fill <= r_fill + QUEUE_CNT_W'(1);
            end else if (w_rd && !w_wr) begin
                r_fill <= r_fill - QUEUE_CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

endmodule

`default_nettype wire

// ----- design/wgra_back.sv -----
// ----------------------------------------------------------------------------
// wgra_back
// Table read, amplitude scaling, offset and clamp, running min/max and alarm.
// ----------------------------------------------------------------------------
`default_nettype none

module wgra_back (
    input  wire                                    i_clk,
    input  wire                                    i_rst_n,
    input  wire wgra_pkg::t_cfg                    i_cfg,
    input  wire wgra_pkg::t_job                    i_job,
    input  wire                                    i_empty,
    output logic                                   o_pop,
    output logic                                   o_valid,
    input  wire                                    i_ready,
    output logic signed [wgra_pkg::SAMPLE_W-1:0]   o_sample_value,
    output logic signed [wgra_pkg::SAMPLE_W-1:0]   o_lowest_value,
    output logic signed [wgra_pkg::SAMPLE_W-1:0]   o_highest_value,
    output logic                                   o_range_alarm,
    output logic [wgra_pkg::COUNT_W-1:0]           o_samples_done
);
    import wgra_pkg::*;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_MUL  = 3'd1;
    localparam logic [2:0] ST_RND  = 3'd2;
    localparam logic [2:0] ST_SUM  = 3'd3;
    localparam logic [2:0] ST_OUT  = 3'd4;

    localparam t_sine_rom SineRom = sine_rom_init();

    localparam logic [PROD_W-1:0] SINE_ROUND = PROD_W'(1) << (SINE_FRACTION_BITS - 1);
    localparam logic [PROD_W-1:0] RAMP_ROUND = PROD_W'(1) << (PHASE_W - 1);

    logic [2:0]                     r_state;
    t_job                           r_job;
    logic signed [SINE_ENTRY_W-1:0] r_sine;
    logic [PROD_W-1:0]              r_prod;
    logic                           r_neg;
    logic signed [WAVE_W-1:0]       r_wave;
    logic signed [SAMPLE_W-1:0]     r_value;
    logic signed [SAMPLE_W-1:0]     r_min;
    logic signed [SAMPLE_W-1:0]     r_max;
    logic signed [SAMPLE_W-1:0]     r_sample;
    logic                           r_alarm;
    logic [COUNT_W-1:0]             r_done;
    logic                           r_out_valid;

    logic                           w_out_load;
    logic signed [SINE_ENTRY_W-1:0] w_entry_abs;
    logic                           w_entry_neg;
    logic                           w_ramp_neg;
    logic [MAG_W-1:0]               w_ramp_mag;
    logic [MAG_W-1:0]               w_mag;
    logic                           n_neg;
    logic [PROD_W-1:0]              w_sine_round;
    logic [PROD_W-1:0]              w_ramp_round;
    logic [WAVE_MAG_W-1:0]          w_wave_mag;
    logic signed [SUM_W-1:0]        w_sum;
    logic signed [SAMPLE_W-1:0]     n_value;
    logic signed [SAMPLE_W-1:0]     n_min;
    logic signed [SAMPLE_W-1:0]     n_max;
    logic                           n_alarm;

    assign o_pop      = (r_state == ST_IDLE) & ~i_empty;
    assign w_out_load = (r_state == ST_OUT) & (~r_out_valid | i_ready);

    always_comb begin
        w_entry_neg = r_sine[SINE_ENTRY_W-1];
        w_entry_abs = w_entry_neg ? -r_sine : r_sine;
        w_ramp_neg  = ~r_job.phase[PHASE_W-1];
        w_ramp_mag  = w_ramp_neg ? (33'h1_0000_0000 - {r_job.phase, 1'b0})
                                 : {1'b0, r_job.phase[PHASE_W-2:0], 1'b0};
        case (r_job.shape)
            WAVE_SINE: begin
                w_mag = {{(MAG_W - SINE_FRACTION_BITS - 1){1'b0}},
                         w_entry_abs[SINE_FRACTION_BITS:0]};
                n_neg = w_entry_neg;
            end
            WAVE_SQUARE: begin
                w_mag = '0;
                n_neg = (r_job.phase > PHASE_HALF);
            end
            default: begin
                w_mag = w_ramp_mag;
                n_neg = w_ramp_neg;
            end
        endcase
    end

    always_comb begin
        w_sine_round = r_prod + SINE_ROUND;
        w_ramp_round = r_prod + RAMP_ROUND;
        case (r_job.shape)
            WAVE_SINE:   w_wave_mag = WAVE_MAG_W'(w_sine_round >> SINE_FRACTION_BITS);
            WAVE_SQUARE: w_wave_mag = WAVE_MAG_W'(i_cfg.amplitude);
            default:     w_wave_mag = w_ramp_round[PROD_W-1:PHASE_W];
        endcase
    end

    always_comb begin
        w_sum = SUM_W'(i_cfg.level_offset) + SUM_W'(r_wave);
        if (w_sum > SUM_W'(SAMPLE_LIMIT)) begin
            n_value = SAMPLE_LIMIT;
        end else if (w_sum < -SUM_W'(SAMPLE_LIMIT)) begin
            n_value = -SAMPLE_LIMIT;
        end else begin
            n_value = SAMPLE_W'(w_sum);
        end
    end

    always_comb begin
        n_min   = (r_job.first || r_value < r_min) ? r_value : r_min;
        n_max   = (r_job.first || r_value > r_max) ? r_value : r_max;
        n_alarm = (r_value > SAMPLE_W'(i_cfg.upper_limit)) ||
                  (r_value < SAMPLE_W'(i_cfg.lower_limit));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
            r_min       <= '0;
            r_max       <= '0;
        end else begin
            case (r_state)
                ST_IDLE: if (o_pop) r_state <= ST_MUL;
                ST_MUL:  r_state <= ST_RND;
                ST_RND:  r_state <= ST_SUM;
                ST_SUM:  r_state <= ST_OUT;
                ST_OUT:  if (w_out_load) r_state <= ST_IDLE;
                default: r_state <= ST_IDLE;
            endcase
            if (w_out_load) begin
                r_out_valid <= 1'b1;
                r_min       <= n_min;
                r_max       <= n_max;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_job  <= i_job;
            r_sine <= SineRom[i_job.phase[PHASE_W-1 -: SINE_INDEX_W]];
        end
        if (r_state == ST_MUL) begin
            r_prod <= PROD_W'(i_cfg.amplitude) * PROD_W'(w_mag);
            r_neg  <= n_neg;
        end
        if (r_state == ST_RND) begin
            r_wave <= r_neg ? -$signed({1'b0, w_wave_mag}) : $signed({1'b0, w_wave_mag});
        end
        if (r_state == ST_SUM) begin
            r_value <= n_value;
        end
        if (w_out_load) begin
            r_sample <= r_value;
            r_alarm  <= n_alarm;
            r_done   <= r_job.count;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_sample_value  = r_sample;
    assign o_lowest_value  = r_min;
    assign o_highest_value = r_max;
    assign o_range_alarm   = r_alarm;
    assign o_samples_done  = r_done;

endmodule

`default_nettype wire

// ----- design/waveform_generator_with_range_alarm.sv -----
// ----------------------------------------------------------------------------
// waveform_generator_with_range_alarm
// Direct digital synthesis sample generator with running min/max and alarm.
// ----------------------------------------------------------------------------
// Each accepted request makes one Q12.16 sample: sine, square, rising saw or
// LFSR noise, scaled by amplitude and shifted by level offset, clamped to
// +/-1100.0. The front end takes a request and forms the phase from the
// registered sample index with a 32x32 multiply (the LFSR state for noise);
// a two-entry queue feeds the back end, which reads the sine table, scales
// with one 23x33 multiplier, adds the offset, clamps and updates min/max in
// states IDLE, MUL, RND, SUM and OUT. The back end takes no new job until
// its result is loaded into the output register. The output register holds a
// result while the next request is already taken. Write configuration only
// while idle.
// ----------------------------------------------------------------------------
`default_nettype none

module waveform_generator_with_range_alarm (
    input  wire                                    i_clk,
    input  wire                                    i_rst_n,
    input  wire                                    i_cfg_we,
    input  wire  [2:0]                             i_cfg_addr,
    input  wire  [31:0]                            i_cfg_wdata,
    input  wire                                    i_valid,
    output logic                                   o_ready,
    input  wire                                    i_restart,
    output logic                                   o_valid,
    input  wire                                    i_ready,
    output logic signed [wgra_pkg::SAMPLE_W-1:0]   o_sample_value,
    output logic signed [wgra_pkg::SAMPLE_W-1:0]   o_lowest_value,
    output logic signed [wgra_pkg::SAMPLE_W-1:0]   o_highest_value,
    output logic                                   o_range_alarm,
    output logic [wgra_pkg::COUNT_W-1:0]           o_samples_done
);
    import wgra_pkg::*;

    localparam logic [AMP_W-1:0]          AMP_RESET   = 23'd65536;
    localparam logic [PHASE_W-1:0]        STEP_RESET  = 32'd429496730;
    localparam logic signed [LEVEL_W-1:0] UPPER_RESET = 27'sd98304;
    localparam logic signed [LEVEL_W-1:0] LOWER_RESET = -27'sd98304;

    t_cfg r_cfg;
    t_job w_push_job;
    t_job w_pop_job;
    logic w_push;
    logic w_pop;
    logic w_full;
    logic w_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.wave_shape   <= WAVE_SINE;
            r_cfg.amplitude    <= AMP_RESET;
            r_cfg.phase_step   <= STEP_RESET;
            r_cfg.level_offset <= '0;
            r_cfg.upper_limit  <= UPPER_RESET;
            r_cfg.lower_limit  <= LOWER_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                CFG_WAVE_SHAPE:   r_cfg.wave_shape   <= i_cfg_wdata[1:0];
                CFG_AMPLITUDE:    r_cfg.amplitude    <= i_cfg_wdata[AMP_W-1:0];
                CFG_PHASE_STEP:   r_cfg.phase_step   <= i_cfg_wdata;
                CFG_LEVEL_OFFSET: r_cfg.level_offset <= i_cfg_wdata[LEVEL_W-1:0];
                CFG_UPPER_LIMIT:  r_cfg.upper_limit  <= i_cfg_wdata[LEVEL_W-1:0];
                CFG_LOWER_LIMIT:  r_cfg.lower_limit  <= i_cfg_wdata[LEVEL_W-1:0];
                default: ;
            endcase
        end
    end

    wgra_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (r_cfg),
        .i_valid   (i_valid),
        .o_ready   (o_ready),
        .i_restart (i_restart),
        .o_push    (w_push),
        .o_job     (w_push_job),
        .i_full    (w_full)
    );

    wgra_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_job   (w_push_job),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_job   (w_pop_job),
        .o_empty (w_empty)
    );

    wgra_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg           (r_cfg),
        .i_job           (w_pop_job),
        .i_empty         (w_empty),
        .o_pop           (w_pop),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_sample_value  (o_sample_value),
        .o_lowest_value  (o_lowest_value),
        .o_highest_value (o_highest_value),
        .o_range_alarm   (o_range_alarm),
        .o_samples_done  (o_samples_done)
    );

endmodule

`default_nettype wire

// ----- design/wgra_checker.sv -----
// ----------------------------------------------------------------------------
// wgra_checker
// Port-level checks of result consistency, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "waveform_generator_with_range_alarm_macros.svh"

module wgra_checker (
    input wire                                    i_clk,
    input wire                                    i_rst_n,
    input wire                                    o_valid,
    input wire                                    i_ready,
    input wire signed [wgra_pkg::SAMPLE_W-1:0]    o_sample_value,
    input wire signed [wgra_pkg::SAMPLE_W-1:0]    o_lowest_value,
    input wire signed [wgra_pkg::SAMPLE_W-1:0]    o_highest_value,
    input wire [wgra_pkg::COUNT_W-1:0]            o_samples_done
);
    import wgra_pkg::*;

    `WGRA_ASSERT_NOW(a_min_le_max, i_clk, i_rst_n, o_valid, o_lowest_value <= o_highest_value, "running min above running max")
    `WGRA_ASSERT_NOW(a_sample_in_span, i_clk, i_rst_n, o_valid, (o_sample_value >= o_lowest_value) && (o_sample_value <= o_highest_value), "sample outside running min/max")
    `WGRA_ASSERT_NOW(a_sample_clamped, i_clk, i_rst_n, o_valid, (o_sample_value <= SAMPLE_LIMIT) && (o_sample_value >= -SAMPLE_LIMIT), "sample beyond clamp limit")
    `WGRA_ASSERT_NOW(a_count_nonzero, i_clk, i_rst_n, o_valid, o_samples_done != '0, "sample count zero on result")
    `WGRA_ASSERT_NEXT(a_hold_stalled, i_clk, i_rst_n, o_valid && !i_ready, o_valid && $stable(o_sample_value), "stalled result dropped or changed")

endmodule

bind waveform_generator_with_range_alarm wgra_checker u_checker (.*);

`default_nettype wire
